[rtl/c2c_pkg.sv]
// Package for the coordinate-to-compressed-row converter.
// Holds sizes, codes, word types and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package c2c_pkg;

   localparam int MAX_ROWS    = 1024;
   localparam int MAX_ENTRIES = 4096;
   localparam int COL_W       = 16;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int ENT_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int VAL_W       = 64;
   localparam int RIDX_W      = 12;
   localparam int RIU_W       = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUES_PRESENT = 1'd1;

   localparam logic [1:0] REQ_LOAD     = 2'd0;
   localparam logic [1:0] REQ_READ_ROW = 2'd1;
   localparam logic [1:0] REQ_READ_SLOT = 2'd2;

   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_ROW_RANGE   = 2'd1;
   localparam logic [1:0] STAT_FULL        = 2'd2;
   localparam logic [1:0] STAT_READ_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ROW_W-1:0]  row_index;
      logic [COL_W-1:0]  col_index;
      logic [VAL_W-1:0]  value_bits;
      logic              is_last;
      logic [RIDX_W-1:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [CNT_W-1:0] row_start;
      logic [CNT_W-1:0] row_nonzeros;
      logic [COL_W-1:0] out_col;
      logic [VAL_W-1:0] out_value;
      logic [CNT_W-1:0] total_nonzeros;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_LD_CLEAR,
      ST_LD_CHECK,
      ST_LD_WRITE,
      ST_PS_READ,
      ST_PS_ACC,
      ST_SC_READ,
      ST_SC_CURSOR,
      ST_SC_WRITE,
      ST_RD_ISSUE,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic clr_start;
      logic clr_step;
      logic ld_check;
      logic ld_write;
      logic ps_start;
      logic ps_read;
      logic ps_acc;
      logic sc_start;
      logic sc_write;
      logic finish;
      logic rd_issue;
      logic resp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic       done;
      logic       is_last;
      logic       load_ok;
      logic       walk_last;
      logic       sc_last;
      logic       loaded_zero;
      logic       rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/c2c_ctrl.sv]
// Sequencer of the converter: loads, row-count clearing, prefix sum, scatter and reads.
// Depends on c2c_pkg; drives the datapath c2c_dp through command structs.
`default_nettype none

module c2c_ctrl
   import c2c_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_type_in,
   input  wire dp_status_type stat,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT_CLEAR: if (stat.walk_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type_in == REQ_LOAD) begin
                  state_in = stat.done ? ST_LD_CLEAR : ST_LD_CHECK;
               end else begin
                  state_in = ST_RD_ISSUE;
               end
            end
         end
         ST_LD_CLEAR: if (stat.walk_last) state_in = ST_LD_CHECK;
         ST_LD_CHECK: begin
            if (stat.load_ok) begin
               state_in = ST_LD_WRITE;
            end else begin
               state_in = stat.is_last ? ST_PS_READ : ST_RESP;
            end
         end
         ST_LD_WRITE: state_in = stat.is_last ? ST_PS_READ : ST_RESP;
         ST_PS_READ: state_in = ST_PS_ACC;
         ST_PS_ACC: begin
            if (!stat.walk_last) begin
               state_in = ST_PS_READ;
            end else begin
               state_in = stat.loaded_zero ? ST_RESP : ST_SC_READ;
            end
         end
         ST_SC_READ: state_in = ST_SC_CURSOR;
         ST_SC_CURSOR: state_in = ST_SC_WRITE;
         ST_SC_WRITE: state_in = stat.sc_last ? ST_RESP : ST_SC_READ;
         ST_RD_ISSUE: state_in = ST_RESP;
         ST_RESP: if (stat.rsp_free) state_in = ST_IDLE;
         default: state_in = ST_INIT_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_INIT_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
            cmd.clr_start = req_valid && (req_type_in == REQ_LOAD) && stat.done;
         end
         ST_LD_CLEAR: cmd.clr_step = 1'b1;
         ST_LD_CHECK: begin
            cmd.ld_check = 1'b1;
            cmd.ps_start = !stat.load_ok && stat.is_last;
         end
         ST_LD_WRITE: begin
            cmd.ld_write = 1'b1;
            cmd.ps_start = stat.is_last;
         end
         ST_PS_READ: cmd.ps_read = 1'b1;
         ST_PS_ACC: begin
            cmd.ps_acc = 1'b1;
            cmd.sc_start = stat.walk_last && !stat.loaded_zero;
            cmd.finish = stat.walk_last && stat.loaded_zero;
         end
         ST_SC_READ: cmd = '0;
         ST_SC_CURSOR: cmd = '0;
         ST_SC_WRITE: begin
            cmd.sc_write = 1'b1;
            cmd.finish = stat.sc_last;
         end
         ST_RD_ISSUE: cmd.rd_issue = 1'b1;
         ST_RESP: cmd.resp_load = stat.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/c2c_dp.sv]
// Datapath of the converter: stores, counters, configuration and the result register.
// Depends on c2c_pkg; commanded by c2c_ctrl.
`default_nettype none

module c2c_dp
   import c2c_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_word_type          req_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              stat,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_word_type               rsp_data
);

   logic [RIU_W-1:0] rows_ff;
   logic             vals_ff;
   logic [RIU_W-1:0] conv_rows_ff;
   logic             conv_vals_ff;
   logic             done_ff;
   logic [CNT_W-1:0] loaded_ff;
   logic [ROW_W-1:0] walk_ff;
   logic [CNT_W-1:0] ent_ff;
   logic [CNT_W-1:0] sum_ff;
   logic [1:0]       status_ff;
   req_word_type     req_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_data_ff;
   rsp_word_type     rsp_data_in;

   logic [CNT_W-1:0] cnt_mem [MAX_ROWS];
   logic [CNT_W-1:0] off_mem [MAX_ROWS];
   logic [CNT_W-1:0] cur_mem [MAX_ROWS];
   logic [ROW_W-1:0] coo_row_mem [MAX_ENTRIES];
   logic [COL_W-1:0] coo_col_mem [MAX_ENTRIES];
   logic [VAL_W-1:0] coo_val_mem [MAX_ENTRIES];
   logic [COL_W-1:0] csr_col_mem [MAX_ENTRIES];
   logic [VAL_W-1:0] csr_val_mem [MAX_ENTRIES];

   logic [CNT_W-1:0] cnt_rd_ff;
   logic [CNT_W-1:0] off_rd_ff;
   logic [CNT_W-1:0] cur_rd_ff;
   logic [ROW_W-1:0] coo_row_rd_ff;
   logic [COL_W-1:0] coo_col_rd_ff;
   logic [VAL_W-1:0] coo_val_rd_ff;
   logic [COL_W-1:0] csr_col_rd_ff;
   logic [VAL_W-1:0] csr_val_rd_ff;

   logic [RIU_W-1:0] eff_rows;
   logic             row_bad;
   logic             buf_full;
   logic             read_ok;
   logic [ROW_W-1:0] cnt_raddr;
   logic             cnt_we;
   logic [ROW_W-1:0] cnt_waddr;
   logic [CNT_W-1:0] cnt_wdata;
   logic             cur_we;
   logic [ROW_W-1:0] cur_waddr;
   logic [CNT_W-1:0] cur_wdata;
   logic             rsp_free;

   always_comb begin
      if (rows_ff == '0) begin
         eff_rows = RIU_W'(1);
      end else if (rows_ff > RIU_W'(MAX_ROWS)) begin
         eff_rows = RIU_W'(MAX_ROWS);
      end else begin
         eff_rows = rows_ff;
      end
   end

   assign row_bad  = {1'b0, req_ff.row_index} >= eff_rows;
   assign buf_full = loaded_ff >= CNT_W'(MAX_ENTRIES);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (req_ff.req_type)
         REQ_READ_ROW:  read_ok = done_ff && ({1'b0, conv_rows_ff} > req_ff.read_index);
         REQ_READ_SLOT: read_ok = done_ff && ({1'b0, req_ff.read_index} < loaded_ff);
         default:       read_ok = 1'b0;
      endcase
   end

   assign stat.done        = done_ff;
   assign stat.is_last     = req_ff.is_last;
   assign stat.load_ok     = !row_bad && !buf_full;
   assign stat.walk_last   = walk_ff == ROW_W'(MAX_ROWS - 1);
   assign stat.sc_last     = (ent_ff + CNT_W'(1)) == loaded_ff;
   assign stat.loaded_zero = loaded_ff == '0;
   assign stat.rsp_free    = rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RIU_W'(MAX_ROWS);
         vals_ff <= 1'b1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE:    rows_ff <= csr_wdata[RIU_W-1:0];
            CSR_VALUES_PRESENT: vals_ff <= csr_wdata[0];
            default:            rows_ff <= rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_rows_ff <= RIU_W'(MAX_ROWS);
         conv_vals_ff <= 1'b1;
         done_ff      <= 1'b0;
         loaded_ff    <= '0;
         walk_ff      <= '0;
         ent_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_start) begin
            done_ff   <= 1'b0;
            loaded_ff <= '0;
            walk_ff   <= '0;
         end
         if (cmd.clr_step || cmd.ps_acc) begin
            walk_ff <= walk_ff + ROW_W'(1);
         end
         if (cmd.ld_write) begin
            loaded_ff <= loaded_ff + CNT_W'(1);
         end
         if (cmd.ps_start) begin
            walk_ff <= '0;
            sum_ff  <= '0;
         end
         if (cmd.ps_acc) begin
            sum_ff <= sum_ff + cnt_rd_ff;
         end
         if (cmd.sc_start) begin
            ent_ff <= '0;
         end
         if (cmd.sc_write) begin
            ent_ff <= ent_ff + CNT_W'(1);
         end
         if (cmd.finish) begin
            done_ff      <= 1'b1;
            conv_rows_ff <= eff_rows;
            conv_vals_ff <= vals_ff;
         end
         if (cmd.resp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.ld_check) begin
         status_ff <= row_bad ? STAT_ROW_RANGE : (buf_full ? STAT_FULL : STAT_OK);
      end
      if (cmd.rd_issue) begin
         status_ff <= read_ok ? STAT_OK : STAT_READ_INVALID;
      end
      if (cmd.resp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Row counter store: cleared by sweeps, bumped by loads, walked by the prefix sum.
   always_comb begin
      if (cmd.ld_check) begin
         cnt_raddr = req_ff.row_index;
      end else if (cmd.ps_read) begin
         cnt_raddr = walk_ff;
      end else begin
         cnt_raddr = req_ff.read_index[ROW_W-1:0];
      end
      cnt_we    = cmd.clr_step || cmd.ld_write;
      cnt_waddr = cmd.clr_step ? walk_ff : req_ff.row_index;
      cnt_wdata = cmd.clr_step ? '0 : cnt_rd_ff + CNT_W'(1);
      cur_we    = cmd.ps_acc || cmd.sc_write;
      cur_waddr = cmd.ps_acc ? walk_ff : coo_row_rd_ff;
      cur_wdata = cmd.ps_acc ? sum_ff : cur_rd_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ps_acc) begin
         off_mem[walk_ff] <= sum_ff;
      end
      off_rd_ff <= off_mem[req_ff.read_index[ROW_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      cur_rd_ff <= cur_mem[coo_row_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_write) begin
         coo_row_mem[loaded_ff[ENT_W-1:0]] <= req_ff.row_index;
         coo_col_mem[loaded_ff[ENT_W-1:0]] <= req_ff.col_index;
         coo_val_mem[loaded_ff[ENT_W-1:0]] <= vals_ff ? req_ff.value_bits : '0;
      end
      coo_row_rd_ff <= coo_row_mem[ent_ff[ENT_W-1:0]];
      coo_col_rd_ff <= coo_col_mem[ent_ff[ENT_W-1:0]];
      coo_val_rd_ff <= coo_val_mem[ent_ff[ENT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.sc_write) begin
         csr_col_mem[cur_rd_ff[ENT_W-1:0]] <= coo_col_rd_ff;
         csr_val_mem[cur_rd_ff[ENT_W-1:0]] <= coo_val_rd_ff;
      end
      csr_col_rd_ff <= csr_col_mem[req_ff.read_index[ENT_W-1:0]];
      csr_val_rd_ff <= csr_val_mem[req_ff.read_index[ENT_W-1:0]];
   end

   always_comb begin
      rsp_data_in                = '0;
      rsp_data_in.status         = status_ff;
      rsp_data_in.total_nonzeros = loaded_ff;
      if (status_ff == STAT_OK && req_ff.req_type == REQ_READ_ROW) begin
         rsp_data_in.row_start    = off_rd_ff;
         rsp_data_in.row_nonzeros = cnt_rd_ff;
      end
      if (status_ff == STAT_OK && req_ff.req_type == REQ_READ_SLOT) begin
         rsp_data_in.out_col   = csr_col_rd_ff;
         rsp_data_in.out_value = conv_vals_ff ? csr_val_rd_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_write |-> loaded_ff < CNT_W'(MAX_ENTRIES))
      else $error("Entry stored into a full buffer.");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sc_write |-> cur_rd_ff < loaded_ff)
      else $error("Scatter slot beyond the loaded entries.");

   a_resp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> rsp_free)
      else $error("Result register overwritten while held.");

   a_done_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(cmd.finish))
      else $error("Conversion marked complete without a finished walk.");

endmodule

`default_nettype wire

[rtl/coo_to_csr_converter_unit.sv]
// Top level of the coordinate-to-compressed-row converter.
// Depends on c2c_pkg, c2c_ctrl and c2c_dp.
`default_nettype none

// Each word in is one request. A load checks the entry, then writes it (an entry dropped
// as out of range or full is not written), after a sweep over all 1024 rows that clears
// the row counts when a load follows a finished conversion; the same sweep runs after
// reset, during which no word is taken. The entry marked last then runs the prefix sum
// (read, accumulate) over all 1024 rows and the scatter (read, cursor, write) per loaded
// entry, both paced by the registered reads they wait on. The result word sits in an
// output register, so the next word may be taken while a result waits.
module coo_to_csr_converter_unit
   import c2c_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_word_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_word_type               rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   c2c_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type_in (req_data.req_type),
      .stat        (stat),
      .cmd         (cmd)
   );

   c2c_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

[sim/tb_coo_to_csr_converter_unit.sv]
// Self-checking testbench for the coordinate-to-compressed-row converter unit.
// Drives load and read words, predicts every result word and compares it field by field.
// Depends on c2c_pkg and coo_to_csr_converter_unit.
`timescale 1ns / 100ps

module tb_coo_to_csr_converter_unit;
   import c2c_pkg::*;

   localparam int DRAIN_CYCLES = 15000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   coo_to_csr_converter_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   req_word_type pending_req[$];
   rsp_word_type expected_rsp[$];
   int  error_count = 0;
   bit  quiet_sender = 1'b0;
   bit  quiet_receiver = 1'b0;
   int  hold_trigger = 0;

   // Shadow of the converter state.
   logic [10:0]      cfg_rows = 11'd1024;
   logic             cfg_values = 1'b1;
   logic [ROW_W-1:0] coo_row[MAX_ENTRIES];
   logic [COL_W-1:0] coo_col[MAX_ENTRIES];
   logic [VAL_W-1:0] coo_val[MAX_ENTRIES];
   int               row_count[MAX_ROWS];
   int               row_base[MAX_ROWS];
   logic [COL_W-1:0] packed_col[MAX_ENTRIES];
   logic [VAL_W-1:0] packed_val[MAX_ENTRIES];
   int               entries_held = 0;
   bit               converted = 1'b0;
   int               converted_rows = 1024;
   bit               converted_values = 1'b1;

   initial begin
      for (int r = 0; r < MAX_ROWS; r++) begin
         row_count[r] = 0;
      end
      forever #10 clock = ~clock;
   end

   function automatic int usable_rows(logic [10:0] rows);
      if (rows == 0) return 1;
      if (rows > MAX_ROWS) return MAX_ROWS;
      return rows;
   endfunction

   task automatic build_csr_tables();
      int sum;
      int cursor[MAX_ROWS];
      int slot;
      sum = 0;
      for (int r = 0; r < MAX_ROWS; r++) begin
         row_base[r] = sum;
         cursor[r] = sum;
         sum += row_count[r];
      end
      for (int i = 0; i < entries_held; i++) begin
         slot = cursor[coo_row[i]];
         packed_col[slot] = coo_col[i];
         packed_val[slot] = coo_val[i];
         cursor[coo_row[i]] = slot + 1;
      end
      converted_rows = usable_rows(cfg_rows);
      converted_values = cfg_values;
      converted = 1'b1;
   endtask

   task automatic predict_csr_response(input req_word_type w);
      rsp_word_type r;
      r = '0;
      case (w.req_type)
         REQ_LOAD: begin
            if (converted) begin
               for (int k = 0; k < MAX_ROWS; k++) begin
                  row_count[k] = 0;
               end
               entries_held = 0;
               converted = 1'b0;
            end
            if (w.row_index >= usable_rows(cfg_rows)) begin
               r.status = STAT_ROW_RANGE;
            end else if (entries_held >= MAX_ENTRIES) begin
               r.status = STAT_FULL;
            end else begin
               coo_row[entries_held] = w.row_index;
               coo_col[entries_held] = w.col_index;
               coo_val[entries_held] = cfg_values ? w.value_bits : '0;
               row_count[w.row_index]++;
               entries_held++;
            end
            if (w.is_last) begin
               build_csr_tables();
            end
         end
         REQ_READ_ROW: begin
            if (!converted || w.read_index >= converted_rows) begin
               r.status = STAT_READ_INVALID;
            end else begin
               r.row_start = row_base[w.read_index];
               r.row_nonzeros = row_count[w.read_index];
            end
         end
         REQ_READ_SLOT: begin
            if (!converted || w.read_index >= entries_held) begin
               r.status = STAT_READ_INVALID;
            end else begin
               r.out_col = packed_col[w.read_index];
               r.out_value = converted_values ? packed_val[w.read_index] : '0;
            end
         end
         default: r.status = STAT_READ_INVALID;
      endcase
      r.total_nonzeros = entries_held;
      expected_rsp.push_back(r);
   endtask

   function automatic req_word_type random_word();
      req_word_type w;
      w.req_type = $urandom;
      w.row_index = $urandom;
      w.col_index = $urandom;
      w.value_bits = {$urandom, $urandom};
      w.is_last = 1'b0;
      w.read_index = $urandom;
      return w;
   endfunction

   function automatic void push_load(int row, logic [COL_W-1:0] col, logic [VAL_W-1:0] v,
                                     bit last);
      req_word_type w;
      w = random_word();
      w.req_type = REQ_LOAD;
      w.row_index = row;
      w.col_index = col;
      w.value_bits = v;
      w.is_last = last;
      pending_req.push_back(w);
   endfunction

   function automatic void push_read(logic [1:0] kind, int idx);
      req_word_type w;
      w = random_word();
      w.req_type = kind;
      w.read_index = idx;
      pending_req.push_back(w);
   endfunction

   // Sender: one word at a time from the pending queue, at times with a random gap before it.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && !req_stall) begin
         predict_csr_response(req_data);
         if (!quiet_sender && $urandom_range(0, 1)) begin
            req_valid <= 1'b0;
            send_gap <= $urandom_range(1, 18);
         end else if (pending_req.size() > 0) begin
            req_data <= pending_req.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_req.size() > 0) begin
            req_data <= pending_req.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Receiver: checks each result word and stalls at random between words.
   int stall_left = 0;
   int hold_left = 0;
   int hold_seen = 0;
   always @(posedge clock) begin
      rsp_word_type e;
      int next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         next_stall = (stall_left > 0) ? stall_left - 1 : 0;
         if (hold_seen != hold_trigger) begin
            hold_seen <= hold_trigger;
            hold_left <= 2000;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result word with nothing expected");
               error_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.row_start !== e.row_start) begin
                  $error("row_start expected %0d actual %0d", e.row_start, rsp_data.row_start);
                  error_count++;
               end
               if (rsp_data.row_nonzeros !== e.row_nonzeros) begin
                  $error("row_nonzeros expected %0d actual %0d", e.row_nonzeros,
                         rsp_data.row_nonzeros);
                  error_count++;
               end
               if (rsp_data.out_col !== e.out_col) begin
                  $error("out_col expected %h actual %h", e.out_col, rsp_data.out_col);
                  error_count++;
               end
               if (rsp_data.out_value !== e.out_value) begin
                  $error("out_value expected %h actual %h", e.out_value, rsp_data.out_value);
                  error_count++;
               end
               if (rsp_data.total_nonzeros !== e.total_nonzeros) begin
                  $error("total_nonzeros expected %0d actual %0d", e.total_nonzeros,
                         rsp_data.total_nonzeros);
                  error_count++;
               end
            end
            next_stall = quiet_receiver ? 0 : $urandom_range(0, 18);
         end
         stall_left <= next_stall;
         rsp_stall <= (next_stall > 0) || (hold_left > 1) || (hold_seen != hold_trigger);
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_ROWS_IN_USE) cfg_rows = data;
      else cfg_values = data[0];
   endtask

   task automatic drain();
      while (pending_req.size() > 0 || req_valid || expected_rsp.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_conversion(int rows);
      int n;
      int reads;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if ($urandom_range(0, 5) == 0) begin
         push_read($urandom_range(1, 2), $urandom_range(0, 4));
      end
      for (int i = 0; i < n; i++) begin
         push_load(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                   : $urandom_range(0, rows - 1), $urandom, {$urandom, $urandom}, i == n - 1);
      end
      reads = $urandom_range(3, 14);
      for (int i = 0; i < reads; i++) begin
         case ($urandom_range(0, 9))
            0: push_read(2'd3, $urandom);
            1: push_read($urandom_range(1, 2), $urandom);
            2, 3, 4: push_read(REQ_READ_ROW, $urandom_range(0, rows));
            default: push_read(REQ_READ_SLOT, $urandom_range(0, n));
         endcase
      end
   endtask

   initial begin
      logic [10:0] rows_pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reads before any conversion, an unknown request, then a small conversion.
      push_read(REQ_READ_ROW, 0);
      push_read(REQ_READ_SLOT, 0);
      push_read(2'd3, 12'hFFF);
      push_load(5, 16'h1234, 64'h0123_4567_89AB_CDEF, 1'b0);
      push_load(1023, 16'hFFFF, '1, 1'b0);
      push_load(0, 16'h0000, '0, 1'b0);
      push_load(5, 16'h0042, 64'h8000_0000_0000_0001, 1'b0);
      push_load(2, 16'h7777, 64'h5555_AAAA_5555_AAAA, 1'b1);
      push_read(REQ_READ_ROW, 0);
      push_read(REQ_READ_ROW, 5);
      push_read(REQ_READ_ROW, 1023);
      push_read(REQ_READ_ROW, 1024);
      push_read(REQ_READ_ROW, 4095);
      for (int s = 0; s < 6; s++) begin
         push_read(REQ_READ_SLOT, s);
      end
      push_read(REQ_READ_SLOT, 4095);
      drain();

      // Row count of zero acts as one; a dropped last entry still converts.
      write_csr(CSR_ROWS_IN_USE, 11'd0);
      push_load(0, 16'hABCD, 64'hDEAD_BEEF_0000_FFFF, 1'b0);
      push_load(1, 16'h0001, 64'h1, 1'b1);
      push_read(REQ_READ_ROW, 0);
      push_read(REQ_READ_ROW, 1);
      push_read(REQ_READ_SLOT, 0);
      drain();

      // Row count above the maximum, values absent.
      write_csr(CSR_ROWS_IN_USE, 11'd2047);
      write_csr(CSR_VALUES_PRESENT, 11'd0);
      push_load(1023, 16'h00FF, '1, 1'b0);
      push_load(512, 16'hFF00, '1, 1'b1);
      push_read(REQ_READ_SLOT, 0);
      push_read(REQ_READ_SLOT, 1);
      push_read(REQ_READ_ROW, 1023);
      drain();

      // Row count lowered in the middle of a load.
      write_csr(CSR_VALUES_PRESENT, 11'd1);
      write_csr(CSR_ROWS_IN_USE, 11'd8);
      push_load(7, 16'h0007, 64'h7, 1'b0);
      push_load(6, 16'h0006, 64'h6, 1'b0);
      drain();
      write_csr(CSR_ROWS_IN_USE, 11'd3);
      push_load(7, 16'h0070, 64'h70, 1'b0);
      push_load(1, 16'h0001, 64'h1, 1'b1);
      for (int s = 0; s < 4; s++) begin
         push_read(REQ_READ_SLOT, s);
      end
      push_read(REQ_READ_ROW, 2);
      push_read(REQ_READ_ROW, 3);
      drain();

      // Fill the entry buffer and overflow it by one.
      write_csr(CSR_ROWS_IN_USE, 11'd16);
      quiet_sender = 1'b1;
      quiet_receiver = 1'b1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         push_load($urandom_range(0, 15), $urandom, {$urandom, $urandom}, 1'b0);
      end
      push_load(3, 16'h3333, 64'h3, 1'b1);
      push_read(REQ_READ_SLOT, MAX_ENTRIES - 1);
      push_read(REQ_READ_ROW, 15);
      for (int i = 0; i < 8; i++) begin
         push_read(REQ_READ_SLOT, $urandom_range(0, MAX_ENTRIES - 1));
      end
      drain();

      // Random conversions under changing settings.
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: rows_pick = $urandom_range(1, 32);
            1: rows_pick = 11'd1024;
            2: rows_pick = (ph == 2) ? 11'd1 : $urandom;
            default: rows_pick = $urandom_range(1, 1024);
         endcase
         write_csr(CSR_ROWS_IN_USE, rows_pick);
         write_csr(CSR_VALUES_PRESENT, $urandom_range(0, 1));
         quiet_sender = ($urandom_range(0, 3) == 0);
         quiet_receiver = ($urandom_range(0, 3) == 0);
         if (ph == 5) begin
            quiet_sender = 1'b1;
            hold_trigger++;
         end
         for (int c = 0; c < 4; c++) begin
            random_conversion(usable_rows(rows_pick));
         end
         drain();
      end

      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
